// ----- sv/spi_bts_pkg.sv -----
// spi_bts_pkg: shared types and codes of the spi burst transfer sequencer
// transaction payload structs, opcode and error codes, controller/datapath links
// no dependencies

package spi_bts_pkg;

    // field widths fixed by the interface
    localparam int SLAVE_ID_W = 3;
    localparam int COUNT_W    = 8;
    localparam int BYTE_W     = 8;
    localparam int CODE_W     = 3;
    localparam int FLAGS_W    = 2;

    // opcodes
    localparam logic [1:0] OP_ENABLE    = 2'd0;
    localparam logic [1:0] OP_START     = 2'd1;
    localparam logic [1:0] OP_BYTE_DONE = 2'd2;
    localparam logic [1:0] OP_QUERY     = 2'd3;

    // start answers
    localparam logic [CODE_W-1:0] ERR_SUCCESS   = 3'd0;
    localparam logic [CODE_W-1:0] ERR_BUSY      = 3'd1;
    localparam logic [CODE_W-1:0] ERR_COLLISION = 3'd2;
    localparam logic [CODE_W-1:0] ERR_SHUTDOWN  = 3'd3;
    localparam logic [CODE_W-1:0] ERR_FAIL      = 3'd4;

    // slave flags: bit0 complete, bit1 success
    localparam logic [FLAGS_W-1:0] FLAGS_CLEAR   = 2'b00;
    localparam logic [FLAGS_W-1:0] FLAGS_DONE_OK = 2'b11;

    // input transaction
    typedef struct packed {
        logic [1:0]            opcode;
        logic [COUNT_W-1:0]    byte_count;
        logic [SLAVE_ID_W-1:0] slave_id;
        logic [BYTE_W-1:0]     rx_byte;
        logic                  overflow_flag;
        logic                  collision_flag;
    } t_in;

    // result transaction
    typedef struct packed {
        logic [CODE_W-1:0]     error_code;
        logic [CODE_W-1:0]     bus_status;
        logic [BYTE_W-1:0]     rx_data;
        logic [COUNT_W-1:0]    rx_index;
        logic                  rx_valid;
        logic [COUNT_W-1:0]    tx_index;
        logic                  tx_valid;
        logic [SLAVE_ID_W-1:0] select_slave;
        logic                  select_active;
        logic                  burst_done;
        logic                  restart;
        logic [FLAGS_W-1:0]    slave_status;
    } t_out;

    // controller to datapath commands
    typedef struct packed {
        logic              open_burst;
        logic              byte_event;
        logic              query;
        logic              restart;
        logic [CODE_W-1:0] error_code;
        logic [CODE_W-1:0] bus_code;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic last_byte;
        logic slave_ok;
    } t_dp_stat;

endpackage

// ----- sv/spi_bts_ctrl.sv -----
// spi_bts_ctrl: bus state machine of the spi burst transfer sequencer
// decodes each transaction into datapath commands and the start answer
// depends on spi_bts_pkg

module spi_bts_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [1:0]           i_opcode,
    input  logic                 i_overflow,
    input  logic                 i_collision,
    input  spi_bts_pkg::t_dp_stat i_stat,
    output spi_bts_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_STOPPED = 3'd0,
        S_READY   = 3'd1,
        S_COMM    = 3'd2,
        S_WCOL    = 3'd3,
        S_OVF     = 3'd4
    } t_state;

    t_state r_state;
    t_state n_state;
    t_state s_after_ovf;

    // next state and command decode
    always_comb begin
        n_state     = r_state;
        s_after_ovf = r_state;
        o_cmd       = '0;
        case (i_opcode)
            spi_bts_pkg::OP_ENABLE: begin
                if (r_state != S_COMM) begin
                    n_state = S_READY;
                end
            end
            spi_bts_pkg::OP_START: begin
                case (r_state)
                    S_READY: begin
                        if (i_stat.slave_ok) begin
                            n_state          = S_COMM;
                            o_cmd.open_burst = 1'b1;
                            o_cmd.error_code = spi_bts_pkg::ERR_SUCCESS;
                        end else begin
                            o_cmd.error_code = spi_bts_pkg::ERR_FAIL;
                        end
                    end
                    S_COMM:    o_cmd.error_code = spi_bts_pkg::ERR_BUSY;
                    S_WCOL:    o_cmd.error_code = spi_bts_pkg::ERR_COLLISION;
                    S_STOPPED: o_cmd.error_code = spi_bts_pkg::ERR_SHUTDOWN;
                    default:   o_cmd.error_code = spi_bts_pkg::ERR_FAIL;
                endcase
            end
            spi_bts_pkg::OP_BYTE_DONE: begin
                o_cmd.byte_event = 1'b1;
                // overflow is recorded before the close or advance decision
                if (i_overflow) begin
                    s_after_ovf = S_OVF;
                end
                n_state = s_after_ovf;
                if (i_stat.last_byte) begin
                    if (s_after_ovf == S_COMM) begin
                        n_state = S_READY;
                    end
                end else if (i_collision) begin
                    n_state       = S_WCOL;
                    o_cmd.restart = 1'b1;
                end
            end
            default: begin
                o_cmd.query = 1'b1;
            end
        endcase
        if (!i_accept) begin
            n_state = r_state;
        end
        o_cmd.bus_code = n_state;
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_STOPPED;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- sv/spi_bts_dp.sv -----
// spi_bts_dp: datapath of the spi burst transfer sequencer
// byte counters, current slave, per-slave flags and the result register
// depends on spi_bts_pkg

module spi_bts_dp #(
    parameter int NUM_SLAVES = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  spi_bts_pkg::t_in      i_in,
    input  spi_bts_pkg::t_dp_cmd  i_cmd,
    output spi_bts_pkg::t_dp_stat o_stat,
    output logic                  o_done,
    output spi_bts_pkg::t_out     o_result
);

    // only ids that fit the slave id field can ever be addressed
    localparam int ID_SPACE   = 2 ** spi_bts_pkg::SLAVE_ID_W;
    localparam int FLAG_DEPTH = (NUM_SLAVES < ID_SPACE) ? NUM_SLAVES : ID_SPACE;
    localparam int IDX_W      = (FLAG_DEPTH > 1) ? $clog2(FLAG_DEPTH) : 1;

    logic [spi_bts_pkg::COUNT_W-1:0]    r_total;
    logic [spi_bts_pkg::COUNT_W-1:0]    r_count;
    logic [spi_bts_pkg::SLAVE_ID_W-1:0] r_cur;
    logic [spi_bts_pkg::FLAGS_W-1:0]    r_flags [FLAG_DEPTH];
    logic                               r_done;
    spi_bts_pkg::t_out                  r_result;
    spi_bts_pkg::t_out                  n_result;

    logic [spi_bts_pkg::COUNT_W:0]   next_count;
    logic [spi_bts_pkg::COUNT_W-1:0] next_count_w;
    logic [IDX_W-1:0]                sid_idx;
    logic [IDX_W-1:0]                cur_idx;

    assign sid_idx      = IDX_W'(i_in.slave_id);
    assign cur_idx      = IDX_W'(r_cur);
    assign next_count   = {1'b0, r_count} + 1'b1;
    assign next_count_w = next_count[spi_bts_pkg::COUNT_W-1:0];

    // status toward the controller
    assign o_stat.last_byte = (next_count >= {1'b0, r_total});
    assign o_stat.slave_ok  = (int'(i_in.slave_id) < NUM_SLAVES);

    // result of the current transaction
    always_comb begin
        n_result            = '0;
        n_result.error_code = i_cmd.error_code;
        n_result.bus_status = i_cmd.bus_code;
        n_result.restart    = i_cmd.restart;
        if (i_cmd.open_burst) begin
            n_result.tx_valid      = 1'b1;
            n_result.select_slave  = i_in.slave_id;
            n_result.select_active = 1'b1;
        end
        if (i_cmd.byte_event) begin
            n_result.rx_data  = i_in.rx_byte;
            n_result.rx_index = r_count;
            n_result.rx_valid = 1'b1;
            if (o_stat.last_byte) begin
                n_result.select_slave = r_cur;
                n_result.burst_done   = 1'b1;
            end else begin
                n_result.tx_index = next_count_w;
                n_result.tx_valid = 1'b1;
            end
        end
        if (i_cmd.query && o_stat.slave_ok) begin
            n_result.slave_status = r_flags[sid_idx];
        end
    end

    // burst counters and current slave
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_count <= '0;
            r_cur   <= '0;
        end else if (i_accept) begin
            if (i_cmd.open_burst) begin
                r_total <= i_in.byte_count;
                r_count <= '0;
                r_cur   <= i_in.slave_id;
            end else if (i_cmd.byte_event) begin
                if (o_stat.last_byte) begin
                    r_total <= '0;
                    r_count <= '0;
                end else begin
                    r_count <= next_count_w;
                end
            end
        end
    end

    // per-slave complete and success flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < FLAG_DEPTH; k++) begin
                r_flags[k] <= spi_bts_pkg::FLAGS_CLEAR;
            end
        end else if (i_accept) begin
            if (i_cmd.open_burst) begin
                r_flags[sid_idx] <= spi_bts_pkg::FLAGS_CLEAR;
            end else if (i_cmd.byte_event && o_stat.last_byte) begin
                r_flags[cur_idx] <= spi_bts_pkg::FLAGS_DONE_OK;
            end
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_accept;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    // each accepted transaction gives exactly one result in the next cycle
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |=> o_done) else $error("result strobe missing after accept");
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_accept |=> !o_done) else $error("result strobe without accept");
    // a burst close never also asks for a transmit byte
    a_close_no_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.burst_done |-> o_result.rx_valid && !o_result.tx_valid)
        else $error("close with transmit request");
    // a restart only comes with a next-byte request
    a_restart_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.restart |-> o_result.tx_valid && !o_result.burst_done)
        else $error("restart without next byte");

endmodule

// ----- sv/spi_burst_transfer_sequencer.sv -----
// spi_burst_transfer_sequencer: top level of the spi burst sequencer
// joins the bus state controller and the counter/flag datapath
// depends on spi_bts_pkg, spi_bts_ctrl, spi_bts_dp
//
// usage:
//   a command transaction (enable, start, byte done, status query) is
//   presented on i_cmd and taken at a rising edge where start is high and
//   busy is low. busy stays low: one command can be taken every cycle.
//   each command gives exactly one result on o_result, shown for one cycle
//   with o_done high, in the cycle right after the command was taken
//   (throughput 1 command per cycle). the bus state, byte counters and
//   per-slave flags update in that same edge, so the next command sees
//   them; the limit is the single-cycle state update.
//   the receiver cannot stall: a result not taken while o_done is high
//   is gone.
//   after a synchronous reset (i_rst_n low) the bus is stopped, counters
//   and the current slave are zero, all slave flags are clear and no
//   result is pending.

module spi_burst_transfer_sequencer #(
    parameter int NUM_SLAVES = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  spi_bts_pkg::t_in  i_cmd,
    output logic              o_done,
    output spi_bts_pkg::t_out o_result
);

    spi_bts_pkg::t_dp_cmd  dp_cmd;
    spi_bts_pkg::t_dp_stat dp_stat;
    logic                  accept;

    // every command completes without stalling, so busy is tied low
    assign busy   = 1'b0;
    assign accept = start && !busy;

    spi_bts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_opcode    (i_cmd.opcode),
        .i_overflow  (i_cmd.overflow_flag),
        .i_collision (i_cmd.collision_flag),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    spi_bts_dp #(
        .NUM_SLAVES (NUM_SLAVES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_in     (i_cmd),
        .i_cmd    (dp_cmd),
        .o_stat   (dp_stat),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule

// ----- verif/spi_burst_transfer_sequencer_test.sv -----
// spi_burst_transfer_sequencer_test: self-checking bench for the spi burst sequencer
// drives command transactions and checks every result against a cycle-free bus model
// depends on spi_bts_pkg and spi_burst_transfer_sequencer

module spi_burst_transfer_sequencer_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLAVES   = 8;
    localparam int RANDOM_ITEMS = 700;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 4;

    // bus states as reported on bus_status
    typedef enum logic [2:0] {
        BUS_STOPPED = 3'd0,
        BUS_READY   = 3'd1,
        BUS_COMM    = 3'd2,
        BUS_WCOL    = 3'd3,
        BUS_OVF     = 3'd4
    } t_bus_state;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    logic busy;
    spi_bts_pkg::t_in  drv_cmd = '0;
    logic o_done;
    spi_bts_pkg::t_out o_result;

    // bus model state
    t_bus_state                        bus_state = BUS_STOPPED;
    logic [spi_bts_pkg::COUNT_W-1:0]    burst_len = '0;
    logic [spi_bts_pkg::COUNT_W-1:0]    bytes_moved = '0;
    logic [spi_bts_pkg::SLAVE_ID_W-1:0] active_slave = '0;
    logic [spi_bts_pkg::FLAGS_W-1:0]    slave_flags [NUM_SLAVES];

    spi_bts_pkg::t_in  queued_cmds [$];
    spi_bts_pkg::t_out answers_due [$];
    int   mismatch_count = 0;
    int   cycle_count = 0;
    int   burst_left = 0;
    int   gap_left = 0;

    spi_burst_transfer_sequencer #(
        .NUM_SLAVES(NUM_SLAVES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (drv_cmd),
        .o_done  (o_done),
        .o_result(o_result)
    );

    always #1 i_clk = ~i_clk;

    function automatic spi_bts_pkg::t_in make_cmd(logic [1:0] op, logic [7:0] count,
                                                  logic [2:0] sid, logic [7:0] rx,
                                                  logic ovf, logic wcol);
        spi_bts_pkg::t_in c;
        c.opcode         = op;
        c.byte_count     = count;
        c.slave_id       = sid;
        c.rx_byte        = rx;
        c.overflow_flag  = ovf;
        c.collision_flag = wcol;
        return c;
    endfunction

    // apply one command to the bus model and return the answer it owes
    function automatic spi_bts_pkg::t_out bus_answer(spi_bts_pkg::t_in c);
        spi_bts_pkg::t_out r;
        int   next_count;
        r = '0;
        case (c.opcode)
            spi_bts_pkg::OP_ENABLE: begin
                if (bus_state != BUS_COMM) bus_state = BUS_READY;
            end
            spi_bts_pkg::OP_START: begin
                case (bus_state)
                    BUS_COMM:    r.error_code = spi_bts_pkg::ERR_BUSY;
                    BUS_WCOL:    r.error_code = spi_bts_pkg::ERR_COLLISION;
                    BUS_STOPPED: r.error_code = spi_bts_pkg::ERR_SHUTDOWN;
                    BUS_READY: begin
                        if (int'(c.slave_id) >= NUM_SLAVES) begin
                            r.error_code = spi_bts_pkg::ERR_FAIL;
                        end else begin
                            r.error_code = spi_bts_pkg::ERR_SUCCESS;
                            burst_len    = c.byte_count;
                            bytes_moved  = '0;
                            active_slave = c.slave_id;
                            slave_flags[c.slave_id] = spi_bts_pkg::FLAGS_CLEAR;
                            bus_state = BUS_COMM;
                            r.tx_index = '0;
                            r.tx_valid = 1'b1;
                            r.select_slave  = c.slave_id;
                            r.select_active = 1'b1;
                        end
                    end
                    default:     r.error_code = spi_bts_pkg::ERR_FAIL;
                endcase
            end
            spi_bts_pkg::OP_BYTE_DONE: begin
                // overflow is recorded before the collision can overwrite it
                if (c.overflow_flag) bus_state = BUS_OVF;
                r.rx_data  = c.rx_byte;
                r.rx_index = bytes_moved;
                r.rx_valid = 1'b1;
                next_count = int'(bytes_moved) + 1;
                if (next_count >= int'(burst_len)) begin
                    // last byte: release select, mark slave complete and successful
                    r.select_slave = active_slave;
                    r.burst_done   = 1'b1;
                    if (bus_state == BUS_COMM) bus_state = BUS_READY;
                    burst_len   = '0;
                    bytes_moved = '0;
                    if (int'(active_slave) < NUM_SLAVES)
                        slave_flags[active_slave] = spi_bts_pkg::FLAGS_DONE_OK;
                end else begin
                    bytes_moved = next_count[spi_bts_pkg::COUNT_W-1:0];
                    r.tx_index  = bytes_moved;
                    r.tx_valid  = 1'b1;
                    if (c.collision_flag) begin
                        bus_state = BUS_WCOL;
                        r.restart = 1'b1;
                    end
                end
            end
            default: begin
                if (int'(c.slave_id) < NUM_SLAVES) r.slave_status = slave_flags[c.slave_id];
            end
        endcase
        r.bus_status = bus_state;
        return r;
    endfunction

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // driver: bursts of commands separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) answers_due.push_back(bus_answer(drv_cmd));
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (queued_cmds.size() > 0) begin
                    drv_cmd <= queued_cmds.pop_front();
                    start   <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: every strobed result against the oldest owed answer
    always @(posedge i_clk) begin
        spi_bts_pkg::t_out want;
        if (i_rst_n && o_done) begin
            if (answers_due.size() == 0) begin
                $error("result with no transaction outstanding");
                mismatch_count++;
            end else begin
                want = answers_due.pop_front();
                check_field("error_code",    8'(want.error_code),
                            8'(o_result.error_code));
                check_field("bus_status",    8'(want.bus_status),
                            8'(o_result.bus_status));
                check_field("rx_data",       want.rx_data,       o_result.rx_data);
                check_field("rx_index",      want.rx_index,      o_result.rx_index);
                check_field("rx_valid",      8'(want.rx_valid),
                            8'(o_result.rx_valid));
                check_field("tx_index",      want.tx_index,      o_result.tx_index);
                check_field("tx_valid",      8'(want.tx_valid),
                            8'(o_result.tx_valid));
                check_field("select_slave",  8'(want.select_slave),
                            8'(o_result.select_slave));
                check_field("select_active", 8'(want.select_active),
                            8'(o_result.select_active));
                check_field("burst_done",    8'(want.burst_done),
                            8'(o_result.burst_done));
                check_field("restart",       8'(want.restart),
                            8'(o_result.restart));
                check_field("slave_status",  8'(want.slave_status),
                            8'(o_result.slave_status));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("spi_burst_transfer_sequencer_test NOT OK");
            $finish;
        end
    end

    initial begin
        int target;
        int count;
        int sid;
        int n_bytes;
        foreach (slave_flags[k]) slave_flags[k] = spi_bts_pkg::FLAGS_CLEAR;

        // directed: stray byte done, refusals in each state, zero and full length bursts
        queued_cmds.push_back(make_cmd(spi_bts_pkg::OP_QUERY,     8'd0,   3'd0, 8'd0,
                                       1'b0, 1'b0));
        queued_cmds.push_back(make_cmd(spi_bts_pkg::OP_START,     8'd4,   3'd1, 8'd0,
                                       1'b0, 1'b0));
        queued_cmds.push_back(make_cmd(spi_bts_pkg::OP_BYTE_DONE, 8'd0,   3'd0, 8'hff,
                                       1'b0, 1'b0));
        queued_cmds.push_back(make_cmd(spi_bts_pkg::OP_QUERY,     8'd0,   3'd0, 8'd0,
                                       1'b0, 1'b0));
        queued_cmds.push_back(make_cmd(spi_bts_pkg::OP_ENABLE,    8'd0,   3'd0, 8'd0,
                                       1'b0, 1'b0));
        queued_cmds.push_back(make_cmd(spi_bts_pkg::OP_START,     8'd0,   3'd7, 8'd0,
                                       1'b0, 1'b0));
        queued_cmds.push_back(make_cmd(spi_bts_pkg::OP_START,     8'd3,   3'd2, 8'd0,
                                       1'b0, 1'b0));
        queued_cmds.push_back(make_cmd(spi_bts_pkg::OP_ENABLE,    8'd0,   3'd0, 8'd0,
                                       1'b0, 1'b0));
        queued_cmds.push_back(make_cmd(spi_bts_pkg::OP_BYTE_DONE, 8'd0,   3'd0, 8'ha5,
                                       1'b0, 1'b0));
        queued_cmds.push_back(make_cmd(spi_bts_pkg::OP_QUERY,     8'd0,   3'd7, 8'd0,
                                       1'b0, 1'b0));
        queued_cmds.push_back(make_cmd(spi_bts_pkg::OP_START,     8'd255, 3'd5, 8'd0,
                                       1'b0, 1'b0));
        queued_cmds.push_back(make_cmd(spi_bts_pkg::OP_BYTE_DONE, 8'd0,   3'd0, 8'h5a,
                                       1'b1, 1'b1));
        queued_cmds.push_back(make_cmd(spi_bts_pkg::OP_START,     8'd1,   3'd0, 8'd0,
                                       1'b0, 1'b0));
        queued_cmds.push_back(make_cmd(spi_bts_pkg::OP_BYTE_DONE, 8'd0,   3'd0, 8'h00,
                                       1'b1, 1'b0));
        queued_cmds.push_back(make_cmd(spi_bts_pkg::OP_START,     8'd1,   3'd0, 8'd0,
                                       1'b0, 1'b0));
        queued_cmds.push_back(make_cmd(spi_bts_pkg::OP_QUERY,     8'd0,   3'd5, 8'd0,
                                       1'b0, 1'b0));
        queued_cmds.push_back(make_cmd(spi_bts_pkg::OP_ENABLE,    8'd0,   3'd0, 8'd0,
                                       1'b0, 1'b0));
        queued_cmds.push_back(make_cmd(spi_bts_pkg::OP_START,     8'd1,   3'd3, 8'd0,
                                       1'b0, 1'b0));
        queued_cmds.push_back(make_cmd(spi_bts_pkg::OP_BYTE_DONE, 8'd0,   3'd0, 8'h81,
                                       1'b0, 1'b1));
        queued_cmds.push_back(make_cmd(spi_bts_pkg::OP_QUERY,     8'd0,   3'd3, 8'd0,
                                       1'b0, 1'b0));
        queued_cmds.push_back(make_cmd(spi_bts_pkg::OP_START,     8'd2,   3'd6, 8'd0,
                                       1'b0, 1'b0));
        queued_cmds.push_back(make_cmd(spi_bts_pkg::OP_BYTE_DONE, 8'd0,   3'd0, 8'h7e,
                                       1'b0, 1'b0));
        queued_cmds.push_back(make_cmd(spi_bts_pkg::OP_BYTE_DONE, 8'd0,   3'd0, 8'h01,
                                       1'b0, 1'b0));
        queued_cmds.push_back(make_cmd(spi_bts_pkg::OP_QUERY,     8'd0,   3'd6, 8'd0,
                                       1'b0, 1'b0));

        // random: mostly enable/start/byte-done bursts, the rest raw noise
        target = queued_cmds.size() + RANDOM_ITEMS;
        while (queued_cmds.size() < target) begin
            if ($urandom_range(0, 4) == 0) begin
                queued_cmds.push_back(make_cmd(2'($urandom_range(0, 3)),
                                               8'($urandom_range(0, 255)),
                                               3'($urandom_range(0, 7)),
                                               8'($urandom_range(0, 255)),
                                               $urandom_range(0, 1) == 1,
                                               $urandom_range(0, 1) == 1));
            end else begin
                count = ($urandom_range(0, 39) == 0) ? $urandom_range(128, 255)
                                                     : $urandom_range(0, 8);
                sid = $urandom_range(0, 7);
                if ($urandom_range(0, 3) != 0)
                    queued_cmds.push_back(make_cmd(spi_bts_pkg::OP_ENABLE,
                                                   8'($urandom_range(0, 255)),
                                                   3'($urandom_range(0, 7)),
                                                   8'($urandom_range(0, 255)),
                                                   $urandom_range(0, 1) == 1,
                                                   $urandom_range(0, 1) == 1));
                queued_cmds.push_back(make_cmd(spi_bts_pkg::OP_START, 8'(count), 3'(sid),
                                               8'($urandom_range(0, 255)),
                                               $urandom_range(0, 1) == 1,
                                               $urandom_range(0, 1) == 1));
                n_bytes = (count == 0) ? 1 : count;
                for (int b = 0; b < n_bytes; b++) begin
                    case ($urandom_range(0, 19))
                        0: queued_cmds.push_back(make_cmd(spi_bts_pkg::OP_QUERY, 8'd0,
                                                          3'($urandom_range(0, 7)),
                                                          8'd0, 1'b0, 1'b0));
                        1: queued_cmds.push_back(make_cmd(spi_bts_pkg::OP_ENABLE, 8'd0,
                                                          3'd0, 8'd0, 1'b0, 1'b0));
                        2: queued_cmds.push_back(make_cmd(spi_bts_pkg::OP_START,
                                                          8'($urandom_range(0, 255)),
                                                          3'($urandom_range(0, 7)), 8'd0,
                                                          1'b0, 1'b0));
                        default: ;
                    endcase
                    queued_cmds.push_back(make_cmd(spi_bts_pkg::OP_BYTE_DONE,
                                                   8'($urandom_range(0, 255)),
                                                   3'($urandom_range(0, 7)),
                                                   8'($urandom_range(0, 255)),
                                                   $urandom_range(0, 11) == 0,
                                                   $urandom_range(0, 11) == 0));
                end
                if ($urandom_range(0, 1) == 0)
                    queued_cmds.push_back(make_cmd(spi_bts_pkg::OP_QUERY, 8'd0, 3'(sid),
                                                   8'd0, 1'b0, 1'b0));
            end
        end

        // synchronous reset, then let the driver run
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every transaction to be taken and answered
        do @(negedge i_clk); while (queued_cmds.size() != 0 || start);
        while (answers_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatch_count == 0) begin
            $display("spi_burst_transfer_sequencer_test OK");
        end else begin
            $display("spi_burst_transfer_sequencer_test NOT OK");
        end
        $finish;
    end

endmodule
